@@ hw/rtl/sha1md_pkg.sv @@
// sha1md_pkg: shared types, constants and command/status structs for the sha-1 digest block
package sha1md_pkg;

	localparam int unsigned ROUNDS       = 80;
	localparam int unsigned ROUND_W      = 7;
	localparam int unsigned DIGEST_WORDS = 5;
	localparam int unsigned WIDX_W       = 3;
	localparam int unsigned BLOCK_WORDS  = 16;
	localparam int unsigned COUNT_W      = 61;

	localparam logic [ROUND_W-1:0] ROUND_LAST = ROUND_W'(ROUNDS - 1);
	localparam logic [ROUND_W-1:0] ROUND_B1   = ROUND_W'(20);
	localparam logic [ROUND_W-1:0] ROUND_B2   = ROUND_W'(40);
	localparam logic [ROUND_W-1:0] ROUND_B3   = ROUND_W'(60);
	localparam logic [WIDX_W-1:0]  WIDX_LAST  = WIDX_W'(DIGEST_WORDS - 1);

	localparam logic [31:0] K_0 = 32'h5A827999;
	localparam logic [31:0] K_1 = 32'h6ED9EBA1;
	localparam logic [31:0] K_2 = 32'h8F1BBCDC;
	localparam logic [31:0] K_3 = 32'hCA62C1D6;

	localparam logic [7:0] PAD_BYTE = 8'h80;

	typedef logic [31:0] word_t;
	typedef word_t [DIGEST_WORDS-1:0] chain_t;

	localparam chain_t H_INIT = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
		32'hEFCDAB89, 32'h67452301};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_ROUND,
		ST_FINAL,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic               load_byte;
		logic               pad;
		logic               pad_second;
		logic               round_en;
		logic [ROUND_W-1:0] rnd;
		logic               finalise;
		logic               restart;
		logic [WIDX_W-1:0]  word_sel;
	} cmd_t;

	typedef struct packed {
		logic blk_full;
		logic len_fits;
	} status_t;

endpackage

@@ hw/rtl/sha1md_dpath.sv @@
// sha1md_dpath: block buffer and schedule, round unit, chaining words and byte counter
module sha1md_dpath
	import sha1md_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	input  logic [7:0]  data_byte,
	output status_t     st,
	output logic [31:0] digest_word
);

	word_t                w_q [BLOCK_WORDS];
	word_t                pad_w [BLOCK_WORDS];
	chain_t               chain_q;
	word_t                a_q, b_q, c_q, d_q, e_q;
	logic [COUNT_W-1:0]   count_q;
	logic [5:0]           pos;
	logic [63:0]          bit_len;
	logic                 len_fits;
	word_t                f, k, t, w_next;

	assign pos      = count_q[5:0];
	assign bit_len  = {count_q, 3'b000};
	assign len_fits = ~(pos[5] & pos[4] & pos[3]);

	assign st.blk_full = &pos;
	assign st.len_fits = len_fits;

	// padded block: kept bytes, marker byte, zeros, then length when it fits; a second pad block is zeros and length
	always_comb begin
		logic [5:0] a;
		for (int j = 0; j < BLOCK_WORDS; j++) begin
			for (int l = 0; l < 4; l++) begin
				a = 6'(j * 4 + l);
				if (cmd.pad_second || a > pos)
					pad_w[j][8*(3-l) +: 8] = 8'h00;
				else if (a == pos)
					pad_w[j][8*(3-l) +: 8] = PAD_BYTE;
				else
					pad_w[j][8*(3-l) +: 8] = w_q[j][8*(3-l) +: 8];
			end
		end
		if (cmd.pad_second || len_fits) begin
			pad_w[BLOCK_WORDS-2] = bit_len[63:32];
			pad_w[BLOCK_WORDS-1] = bit_len[31:0];
		end
	end

	always_comb begin
		if (cmd.rnd < ROUND_B1) begin
			f = (b_q & c_q) | (~b_q & d_q);
			k = K_0;
		end else if (cmd.rnd < ROUND_B2) begin
			f = b_q ^ c_q ^ d_q;
			k = K_1;
		end else if (cmd.rnd < ROUND_B3) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k = K_2;
		end else begin
			f = b_q ^ c_q ^ d_q;
			k = K_3;
		end
		t      = {a_q[26:0], a_q[31:27]} + f + e_q + k + w_q[0];
		w_next = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
		w_next = {w_next[30:0], w_next[31]};
	end

	always_ff @(posedge clk) begin
		if (cmd.pad) begin
			for (int j = 0; j < BLOCK_WORDS; j++)
				w_q[j] <= pad_w[j];
		end else if (cmd.round_en) begin
			for (int j = 0; j < BLOCK_WORDS - 1; j++)
				w_q[j] <= w_q[j+1];
			w_q[BLOCK_WORDS-1] <= w_next;
		end else if (cmd.load_byte) begin
			w_q[pos[5:2]][8*(3-pos[1:0]) +: 8] <= data_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.round_en) begin
			a_q <= t;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
		end else begin
			a_q <= chain_q[0];
			b_q <= chain_q[1];
			c_q <= chain_q[2];
			d_q <= chain_q[3];
			e_q <= chain_q[4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q <= H_INIT;
			count_q <= '0;
		end else if (cmd.restart) begin
			chain_q <= H_INIT;
			count_q <= '0;
		end else begin
			if (cmd.finalise) begin
				chain_q[0] <= chain_q[0] + a_q;
				chain_q[1] <= chain_q[1] + b_q;
				chain_q[2] <= chain_q[2] + c_q;
				chain_q[3] <= chain_q[3] + d_q;
				chain_q[4] <= chain_q[4] + e_q;
			end
			if (cmd.load_byte)
				count_q <= count_q + COUNT_W'(1);
		end
	end

	always_comb begin
		case (cmd.word_sel)
			3'd0:    digest_word = chain_q[0];
			3'd1:    digest_word = chain_q[1];
			3'd2:    digest_word = chain_q[2];
			3'd3:    digest_word = chain_q[3];
			default: digest_word = chain_q[4];
		endcase
	end

endmodule

@@ hw/rtl/sha1md_ctrl.sv @@
// sha1md_ctrl: sequencing of byte intake, padding, rounds and digest output
module sha1md_ctrl
	import sha1md_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              byte_present,
	input  logic              message_end,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [WIDX_W-1:0] word_index,
	output logic              last_word,
	input  status_t           st,
	output cmd_t              cmd
);

	state_t             state_q, state_d;
	logic [ROUND_W-1:0] rnd_q;
	logic [WIDX_W-1:0]  widx_q;
	logic               end_q, last_q, pad2_q;
	logic               in_xfer, out_xfer, done;

	assign in_xfer  = in_valid && in_ready;
	assign out_xfer = out_valid && out_ready;
	assign done     = out_xfer && (widx_q == WIDX_LAST);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (byte_present && st.blk_full)
						state_d = ST_ROUND;
					else if (message_end)
						state_d = ST_PAD;
				end
			end
			ST_PAD:   state_d = ST_ROUND;
			ST_ROUND: if (rnd_q == ROUND_LAST) state_d = ST_FINAL;
			ST_FINAL: begin
				if (last_q)
					state_d = ST_OUT;
				else if (end_q)
					state_d = ST_PAD;
				else
					state_d = ST_IDLE;
			end
			ST_OUT:   if (done) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready       = (state_q == ST_IDLE);
		out_valid      = (state_q == ST_OUT);
		word_index     = widx_q;
		last_word      = (widx_q == WIDX_LAST);
		cmd.load_byte  = in_xfer && byte_present;
		cmd.pad        = (state_q == ST_PAD);
		cmd.pad_second = pad2_q;
		cmd.round_en   = (state_q == ST_ROUND);
		cmd.rnd        = rnd_q;
		cmd.finalise   = (state_q == ST_FINAL);
		cmd.restart    = done;
		cmd.word_sel   = widx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rnd_q   <= '0;
			widx_q  <= '0;
			end_q   <= 1'b0;
			last_q  <= 1'b0;
			pad2_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_ROUND)
				rnd_q <= (rnd_q == ROUND_LAST) ? '0 : rnd_q + ROUND_W'(1);
			if (in_xfer)
				end_q <= message_end;
			if (state_q == ST_PAD) begin
				last_q <= pad2_q || st.len_fits;
				pad2_q <= !(pad2_q || st.len_fits);
			end
			if (out_xfer)
				widx_q <= done ? '0 : widx_q + WIDX_W'(1);
			if (done) begin
				end_q  <= 1'b0;
				last_q <= 1'b0;
				pad2_q <= 1'b0;
			end
		end
	end

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input and output open together");

	a_round_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND) |-> (rnd_q <= ROUND_LAST))
		else $error("round counter out of range");

	a_final_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINAL && last_q) |=> (state_q == ST_OUT))
		else $error("digest not presented after last block");

	a_widx_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (widx_q <= WIDX_LAST))
		else $error("word index out of range");

	a_round_start: assert property (@(posedge clk) disable iff (!arst_n)
		($rose(state_q == ST_ROUND)) |-> (rnd_q == '0))
		else $error("rounds started mid-count");

endmodule

@@ hw/rtl/sha1_message_digest.sv @@
// sha1_message_digest: top level of the streaming sha-1 digest block
// Takes at most one byte per input transfer; a transfer that carries no
// 64th byte of a block and no message end leaves the input ready. The 64th
// byte of a block starts the rounds on the single round unit and then the
// chaining add, during which input is held off. A message end adds a padding
// step and the rounds and chaining add for the closing block, with a second
// padding step and closing block when the message leaves 56 or more bytes in
// its last block, and then presents the five digest words as five output
// transfers, word 0 first. After the fifth word is taken the block is back at the initial hash values.
module sha1_message_digest
	import sha1md_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        byte_present,
	input  logic        message_end,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	cmd_t    cmd;
	status_t st;

	sha1md_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.byte_present (byte_present),
		.message_end  (message_end),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.word_index   (word_index),
		.last_word    (last_word),
		.st           (st),
		.cmd          (cmd)
	);

	sha1md_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.data_byte   (data_byte),
		.st          (st),
		.digest_word (digest_word)
	);

endmodule

@@ test/sha1_digest_checker.sv @@
// sha1_digest_checker: predicts sha-1 digests from input transfers and checks every output word
module sha1_digest_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        byte_present,
	input  logic        message_end,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [31:0] digest_word,
	input  logic [2:0]  word_index,
	input  logic        last_word,
	output int          words_due,
	output int          mismatches
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [31:0] IV_0 = 32'h67452301;
	localparam logic [31:0] IV_1 = 32'hEFCDAB89;
	localparam logic [31:0] IV_2 = 32'h98BADCFE;
	localparam logic [31:0] IV_3 = 32'h10325476;
	localparam logic [31:0] IV_4 = 32'hC3D2E1F0;

	localparam logic [31:0] RK_0 = 32'h5A827999;
	localparam logic [31:0] RK_1 = 32'h6ED9EBA1;
	localparam logic [31:0] RK_2 = 32'h8F1BBCDC;
	localparam logic [31:0] RK_3 = 32'hCA62C1D6;

	localparam logic [7:0] PAD_MARK = 8'h80;

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  idx;
		logic        last;
	} digest_beat_t;

	digest_beat_t digest_due[$];

	logic [31:0] hash_state [5];
	logic [7:0]  block_bytes [64];
	logic [60:0] msg_len;

	function automatic void restart_message();
		hash_state = '{IV_0, IV_1, IV_2, IV_3, IV_4};
		msg_len = '0;
	endfunction

	function automatic void mix_block();
		logic [31:0] w [80];
		logic [31:0] a, b, c, d, e, f, k, t;
		for (int i = 0; i < 16; i++)
			w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2],
				block_bytes[4*i+3]};
		for (int i = 16; i < 80; i++) begin
			t = w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16];
			w[i] = {t[30:0], t[31]};
		end
		a = hash_state[0];
		b = hash_state[1];
		c = hash_state[2];
		d = hash_state[3];
		e = hash_state[4];
		for (int i = 0; i < 80; i++) begin
			if (i < 20) begin
				f = (b & c) | (~b & d);
				k = RK_0;
			end else if (i < 40) begin
				f = b ^ c ^ d;
				k = RK_1;
			end else if (i < 60) begin
				f = (b & c) | (b & d) | (c & d);
				k = RK_2;
			end else begin
				f = b ^ c ^ d;
				k = RK_3;
			end
			t = {a[26:0], a[31:27]} + f + e + k + w[i];
			e = d;
			d = c;
			c = {b[1:0], b[31:2]};
			b = a;
			a = t;
		end
		hash_state[0] += a;
		hash_state[1] += b;
		hash_state[2] += c;
		hash_state[3] += d;
		hash_state[4] += e;
	endfunction

	function automatic void absorb_byte(input logic [7:0] value);
		int pos;
		pos = msg_len[5:0];
		block_bytes[pos] = value;
		msg_len++;
		if (pos == 63)
			mix_block();
	endfunction

	function automatic void close_message();
		logic [63:0] bit_len;
		int pos;
		digest_beat_t beat;
		bit_len = {msg_len, 3'b000};
		pos = msg_len[5:0];
		block_bytes[pos] = PAD_MARK;
		pos++;
		// length field no longer fits, so an extra block is needed
		if (pos > 56) begin
			while (pos < 64) begin
				block_bytes[pos] = '0;
				pos++;
			end
			mix_block();
			pos = 0;
		end
		while (pos < 56) begin
			block_bytes[pos] = '0;
			pos++;
		end
		for (int i = 0; i < 8; i++)
			block_bytes[56+i] = bit_len[63-8*i -: 8];
		mix_block();
		for (int i = 0; i < 5; i++) begin
			beat.word = hash_state[i];
			beat.idx  = 3'(i);
			beat.last = (i == 4);
			digest_due.insert(digest_due.size(), beat);
		end
		restart_message();
	endfunction

	function automatic void check_word();
		digest_beat_t want;
		if (digest_due.size() == 0) begin
			$error("digest word %h (index %0d) with nothing expected", digest_word,
				word_index);
			mismatches++;
			return;
		end
		want = digest_due.pop_front();
		if (digest_word !== want.word) begin
			$error("digest_word: expected %h, got %h", want.word, digest_word);
			mismatches++;
		end
		if (word_index !== want.idx) begin
			$error("word_index: expected %0d, got %0d", want.idx, word_index);
			mismatches++;
		end
		if (last_word !== want.last) begin
			$error("last_word: expected %0b, got %0b", want.last, last_word);
			mismatches++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restart_message();
			digest_due.delete();
			mismatches = 0;
		end else begin
			if (out_valid && out_ready)
				check_word();
			if (in_valid && in_ready) begin
				if (byte_present)
					absorb_byte(data_byte);
				if (message_end)
					close_message();
			end
		end
		words_due = digest_due.size();
	end

endmodule

@@ test/sha1_message_digest_test.sv @@
// sha1_message_digest_test: stimulus, flow control and verdict for the sha-1 digest block
module sha1_message_digest_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int          ITEM_TARGET = 410;
	localparam int          SETTLE_CYCLES = 400;

	typedef enum {
		RX_OPEN,
		RX_COIN,
		RX_CHOKED,
		RX_PERIODIC
	} rx_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = 8'h00;
	logic        byte_present = 1'b0;
	logic        message_end = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	int          words_due;
	int          mismatches;
	int unsigned cycles = 0;

	int burst_left = 0;
	int message_items = 0;
	int ignored_items = 0;
	int messages = 0;
	int message_bytes = 0;
	int longest = 0;

	sha1_message_digest dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.data_byte    (data_byte),
		.byte_present (byte_present),
		.message_end  (message_end),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.digest_word  (digest_word),
		.word_index   (word_index),
		.last_word    (last_word)
	);

	sha1_digest_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.data_byte    (data_byte),
		.byte_present (byte_present),
		.message_end  (message_end),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.digest_word  (digest_word),
		.word_index   (word_index),
		.last_word    (last_word),
		.words_due    (words_due),
		.mismatches   (mismatches)
	);

	initial begin
		forever begin
			#5 clk = ~clk;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d digest words outstanding", cycles,
				words_due);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// receiver stall pattern
	initial begin
		rx_mode_t mode;
		@(posedge arst_n);
		forever begin
			mode = rx_mode_t'($urandom_range(0, 3));
			repeat ($urandom_range(8, 80)) begin
				@(posedge clk);
				case (mode)
				RX_OPEN: begin
					out_ready <= 1'b1;
				end
				RX_COIN: begin
					out_ready <= 1'($urandom_range(0, 1));
				end
				RX_CHOKED: begin
					out_ready <= ($urandom_range(0, 3) == 0);
				end
				default: begin
					out_ready <= (cycles % 5 != 0);
				end
				endcase
			end
		end
	end

	task automatic send_item(input logic [7:0] value, input logic present, input logic fin);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150) :
				$urandom_range(1, 20);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				data_byte <= 8'($urandom);
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		data_byte <= value;
		byte_present <= present;
		message_end <= fin;
		do @(posedge clk); while (in_ready !== 1'b1);
		if (present || fin)
			message_items++;
		else
			ignored_items++;
	endtask

	task automatic send_message(input int len);
		logic joined;
		joined = (len > 0) && ($urandom_range(0, 1) == 1);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 9) == 0)
				send_item(8'($urandom), 1'b0, 1'b0);
			send_item(8'($urandom), 1'b1, joined && (i == len - 1));
		end
		// end transfer without a byte, the data bits are don't-care
		if (!joined)
			send_item(8'($urandom), 1'b0, 1'b1);
		messages++;
		message_bytes += len;
		if (len > longest)
			longest = len;
	endtask

	task automatic wait_for_digests();
		in_valid <= 1'b0;
		@(negedge clk);
		while (words_due != 0) @(negedge clk);
		@(posedge clk);
		burst_left = 0;
	endtask

	initial begin
		int len;
		int pick;
		bit paused;
		paused = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty message, twice: plain end and end with nonzero don't-care data
		send_item(8'h00, 1'b0, 1'b1);
		send_item(8'hFF, 1'b0, 1'b1);
		// transfers that carry nothing
		send_item(8'hAA, 1'b0, 1'b0);
		send_item(8'h55, 1'b0, 1'b0);
		// extremes, last byte together with the end
		send_item(8'h00, 1'b1, 1'b0);
		send_item(8'hFF, 1'b1, 1'b0);
		send_item(8'h80, 1'b1, 1'b1);
		// "abc" closed by a separate end
		send_item(8'h61, 1'b1, 1'b0);
		send_item(8'h62, 1'b1, 1'b0);
		send_item(8'h63, 1'b1, 1'b0);
		send_item(8'h3C, 1'b0, 1'b1);
		// one byte message
		send_item(8'h01, 1'b1, 1'b1);
		messages += 5;
		message_bytes += 7;
		longest = 3;

		while (message_items + ignored_items < ITEM_TARGET) begin
			if (!paused && message_items >= ITEM_TARGET / 2) begin
				wait_for_digests();
				paused = 1'b1;
			end
			pick = $urandom_range(0, 9);
			if (pick <= 5) begin
				len = $urandom_range(0, 12);
			end else if (pick <= 7) begin
				len = $urandom_range(13, 50);
			end else if (pick == 8) begin
				len = 55 + 8 * $urandom_range(0, 1) + $urandom_range(0, 1);
			end else begin
				len = 119 + 8 * $urandom_range(0, 1) + $urandom_range(0, 1);
			end
			send_message(len);
		end

		wait_for_digests();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("covered %0d messages, %0d message bytes, longest %0d bytes", messages,
			message_bytes, longest);
		$display("%0d message transfers and %0d ignored transfers in %0d cycles",
			message_items, ignored_items, cycles);
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

@@ sim.f @@
hw/rtl/sha1md_pkg.sv
hw/rtl/sha1md_dpath.sv
hw/rtl/sha1md_ctrl.sv
hw/rtl/sha1_message_digest.sv
test/sha1_digest_checker.sv
test/sha1_message_digest_test.sv
